[rtl/srt_pkg.sv]
package srt_pkg;

	localparam int NAME_W = 64;
	localparam int ADDR_W = 48;
	localparam int CNT_W  = 32;
	localparam int SLOT_W = 5;
	localparam int SIZE_W = 6;

	typedef enum logic [1:0] {
		ACT_REGISTER  = 2'd0,
		ACT_UNREG_NA  = 2'd1,
		ACT_UNREG_A   = 2'd2,
		ACT_LOOKUP    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NOMATCH = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [NAME_W-1:0] service_name;
		logic [ADDR_W-1:0] server_address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot_index;
		logic [ADDR_W-1:0] entry_address;
		logic [CNT_W-1:0]  change_count;
		logic              last;
	} rsp_t;

	// Compare bytes from the top; stop at the first zero byte both share.
	function automatic logic names_match(input logic [NAME_W-1:0] a,
			input logic [NAME_W-1:0] b, input int nbytes);
		logic done;
		logic res;
		done = 1'b0;
		res  = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (!done && i < nbytes) begin
				if (a[56-8*i +: 8] != b[56-8*i +: 8]) begin
					res  = 1'b0;
					done = 1'b1;
				end else if (a[56-8*i +: 8] == 8'd0) begin
					done = 1'b1;
				end
			end
		end
		return res;
	endfunction

endpackage

[rtl/service_registry_table_unit.sv]
// The back-end scans one slot per cycle over the first n slots, n being table_size
// capped at TABLE_DEPTH (register stops early on a hit), then sends the final result word.
// A two-entry queue takes commands while the scan runs; busy rises when full.
// Reset clears valid bits, names, addresses, change counter and the queue;
// table_size goes to 32. Results are strobed for one cycle; the receiver cannot stall.
module service_registry_table_unit import srt_pkg::*; #(
	parameter int TABLE_DEPTH = 32,
	parameter int NAME_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  req_t        req,
	output logic        busy,
	output logic        done,
	output rsp_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [SIZE_W-1:0] size_q;
	logic              q_valid, pop;
	req_t              q_head;

	// Single register at address zero; other addresses drop the write.
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {{(32-SIZE_W){1'b0}}, size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(32);
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	srt_front #(.QDEPTH(2)) u_front (
		.clk, .arst_n, .start, .req, .pop, .busy, .q_valid, .q_head
	);

	srt_back #(.DEPTH(TABLE_DEPTH), .NBYTES(NAME_BYTES)) u_back (
		.clk, .arst_n, .q_valid, .q_head, .table_size(size_q), .pop,
		.rsp_valid(done), .rsp(result)
	);
endmodule

[rtl/srt_front.sv]
// Input side: take a command word and push it to the queue.
module srt_front import srt_pkg::*; #(
	parameter int QDEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	input  logic pop,
	output logic busy,
	output logic q_valid,
	output req_t q_head
);
	localparam int QW = $clog2(QDEPTH);
	req_t          mem_q [QDEPTH];
	logic [QW-1:0] wp_q, rp_q;
	logic [QW:0]   cnt_q;
	logic          push;

	assign busy    = (cnt_q == (QW+1)'(QDEPTH));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign q_head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == QW'(QDEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == QW'(QDEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end
endmodule

[rtl/srt_back.sv]
// Table and scan sequencer: one slot per cycle.
module srt_back import srt_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int NBYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  req_t              q_head,
	input  logic [SIZE_W-1:0] table_size,
	output logic              pop,
	output logic              rsp_valid,
	output rsp_t              rsp
);
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [DEPTH-1:0]  valid_q;
	logic [NAME_W-1:0] name_q [DEPTH];
	logic [ADDR_W-1:0] addr_q [DEPTH];
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W:0]   idx_q;
	logic [SLOT_W-1:0] slot;
	logic              found_q;
	logic              idle_hit_q;
	logic [SLOT_W-1:0] idle_q;
	logic [SIZE_W-1:0] n_act;
	logic              in_range;
	logic              nm, am, sv;

	assign n_act    = (table_size > SIZE_W'(DEPTH)) ? SIZE_W'(DEPTH) : table_size;
	assign in_range = ({1'b0, idx_q} < {1'b0, n_act});
	assign slot     = idx_q[SLOT_W-1:0];
	assign sv       = valid_q[slot];
	assign nm       = names_match(name_q[slot], q_head.service_name, NBYTES);
	assign am       = (addr_q[slot] == q_head.server_address);
	assign pop      = (state_q == S_DONE);

	// Idle entries still match on unregister, so names and addresses start at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				name_q[i] <= '0;
				addr_q[i] <= '0;
			end
		end else if (state_q == S_DONE && q_head.action == ACT_REGISTER && !found_q
				&& idle_hit_q) begin
			name_q[idle_q] <= q_head.service_name;
			addr_q[idle_q] <= q_head.server_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			cnt_q      <= '0;
			idx_q      <= '0;
			found_q    <= 1'b0;
			idle_hit_q <= 1'b0;
			idle_q     <= '0;
			rsp_valid  <= 1'b0;
			rsp        <= '0;
		end else begin
			rsp_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0; found_q <= 1'b0; idle_hit_q <= 1'b0; idle_q <= '0;
					if (q_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!in_range || (q_head.action == ACT_REGISTER && found_q)) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						unique case (q_head.action)
							ACT_REGISTER: begin
								if (sv && am && nm) begin
									found_q <= 1'b1; idle_q <= slot;
								end else if (!sv && !idle_hit_q) begin
									idle_hit_q <= 1'b1; idle_q <= slot;
								end
							end
							ACT_UNREG_NA, ACT_UNREG_A: begin
								if (am && (q_head.action == ACT_UNREG_A || nm)) begin
									valid_q[slot] <= 1'b0; found_q <= 1'b1;
								end
							end
							default: begin
								if (sv && nm) begin
									found_q   <= 1'b1;
									rsp_valid <= 1'b1;
									rsp       <= '{ST_OK, slot, addr_q[slot], cnt_q, 1'b0};
								end
							end
						endcase
					end
				end
				S_DONE: begin
					state_q   <= S_IDLE;
					rsp_valid <= 1'b1;
					unique case (q_head.action)
						ACT_REGISTER: begin
							if (found_q)
								rsp <= '{ST_OK, idle_q, '0, cnt_q, 1'b1};
							else if (idle_hit_q) begin
								valid_q[idle_q] <= 1'b1;
								cnt_q <= cnt_q + 1'b1;
								rsp <= '{ST_OK, idle_q, '0, cnt_q + 1'b1, 1'b1};
							end else
								rsp <= '{ST_FULL, '0, '0, cnt_q, 1'b1};
						end
						ACT_UNREG_NA, ACT_UNREG_A: begin
							if (found_q) begin
								cnt_q <= cnt_q + 1'b1;
								rsp <= '{ST_OK, '0, '0, cnt_q + 1'b1, 1'b1};
							end else
								rsp <= '{ST_NOMATCH, '0, '0, cnt_q, 1'b1};
						end
						default: begin
							rsp <= '{found_q ? ST_OK : ST_NOMATCH, '0, '0, cnt_q, 1'b1};
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[bench/service_registry_table_unit_test.sv]
`timescale 1ns / 100ps

module service_registry_table_unit_test;
	import srt_pkg::*;

	localparam int DEPTH = 32;
	localparam logic [1:0] REG_TABLE_SIZE = 2'd0;

	// Predictor of the registry table: holds its own copy of slots and counter.
	class registry_scoreboard;
		logic              slot_live [DEPTH];
		logic [NAME_W-1:0] slot_key  [DEPTH];
		logic [ADDR_W-1:0] slot_addr [DEPTH];
		logic [CNT_W-1:0]  changes;
		int                size_reg;
		rsp_t              pending_words[$];
		int                mismatches;

		function void clear();
			for (int i = 0; i < DEPTH; i++) begin
				slot_live[i] = 1'b0;
				slot_key[i]  = '0;
				slot_addr[i] = '0;
			end
			changes = '0;
			size_reg = 32;
			pending_words.delete();
			mismatches = 0;
		endfunction

		function bit same_name(logic [NAME_W-1:0] a, logic [NAME_W-1:0] b);
			for (int i = 0; i < 8; i++) begin
				if (a[56-8*i +: 8] != b[56-8*i +: 8])
					return 0;
				if (a[56-8*i +: 8] == 8'd0)
					return 1;
			end
			return 1;
		endfunction

		function void push_word(status_t st, int slot, logic [ADDR_W-1:0] addr, bit fin);
			rsp_t w;
			w.status        = st;
			w.slot_index    = slot[SLOT_W-1:0];
			w.entry_address = addr;
			w.change_count  = changes;
			w.last          = fin;
			pending_words.insert(pending_words.size(), w);
		endfunction

		function void note_command(req_t r);
			int n;
			int idle;
			int hits;
			bit any;
			n = (size_reg > DEPTH) ? DEPTH : size_reg;
			idle = -1;
			hits = 0;
			any = 0;
			case (action_t'(r.action))
				ACT_REGISTER: begin
					for (int i = 0; i < n; i++) begin
						if (slot_live[i]) begin
							if (slot_addr[i] == r.server_address &&
									same_name(slot_key[i], r.service_name)) begin
								push_word(ST_OK, i, '0, 1);
								return;
							end
						end else if (idle < 0) begin
							idle = i;
						end
					end
					if (idle < 0) begin
						push_word(ST_FULL, 0, '0, 1);
					end else begin
						slot_live[idle] = 1'b1;
						slot_key[idle]  = r.service_name;
						slot_addr[idle] = r.server_address;
						changes++;
						push_word(ST_OK, idle, '0, 1);
					end
				end
				ACT_UNREG_NA, ACT_UNREG_A: begin
					for (int i = 0; i < n; i++) begin
						if (slot_addr[i] == r.server_address && (r.action == ACT_UNREG_A ||
								same_name(r.service_name, slot_key[i]))) begin
							slot_live[i] = 1'b0;
							any = 1;
						end
					end
					if (any)
						changes++;
					push_word(any ? ST_OK : ST_NOMATCH, 0, '0, 1);
				end
				default: begin
					for (int i = 0; i < n; i++) begin
						if (slot_live[i] && same_name(slot_key[i], r.service_name)) begin
							push_word(ST_OK, i, slot_addr[i], 0);
							hits++;
						end
					end
					push_word(hits > 0 ? ST_OK : ST_NOMATCH, 0, '0, 1);
				end
			endcase
		endfunction

		function void check_word(rsp_t got);
			rsp_t want;
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %p", got);
				return;
			end
			want = pending_words.pop_front();
			if (got.status !== want.status || got.slot_index !== want.slot_index ||
					got.entry_address !== want.entry_address ||
					got.change_count !== want.change_count || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("word mismatch: expected %p got %p", want, got);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	req_t        req = '0;
	logic        busy;
	logic        done;
	rsp_t        result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	registry_scoreboard board;

	// Small pools of names and addresses so that commands collide often.
	logic [NAME_W-1:0] name_pool [8];
	logic [ADDR_W-1:0] addr_pool [6];

	service_registry_table_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	// Check every strobed result word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_word(result);
	end

	// Write one register: setup cycle, then access cycle; release afterwards.
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= idx;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_TABLE_SIZE)
			board.size_reg = int'(val[SIZE_W-1:0]);
	endtask

	// Issue one command word, hold start until the block takes it.
	// Drop start only when a gap follows, so back-to-back words keep it high.
	task automatic send_command(action_t act, logic [NAME_W-1:0] nm,
			logic [ADDR_W-1:0] ad);
		int gap;
		req_t r;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.action = act;
		r.service_name = nm;
		r.server_address = ad;
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_command(r);
	endtask

	// Drain every expected word, then allow a full scan of slack.
	task automatic drain();
		start <= 1'b0;
		while (board.pending_words.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
	endtask

	function automatic logic [NAME_W-1:0] rand_name();
		logic [NAME_W-1:0] nm;
		int len;
		nm = {$urandom, $urandom};
		len = $urandom_range(0, 8);
		// Zero-pad the tail so the early-stop compare gets exercised.
		for (int i = len; i < 8; i++)
			nm[56-8*i +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'd0;
		return nm;
	endfunction

	task automatic random_phase(int count);
		int pick;
		logic [NAME_W-1:0] nm;
		logic [ADDR_W-1:0] ad;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 9);
			nm = (pick < 8) ? name_pool[$urandom_range(0, 7)] : rand_name();
			ad = (pick < 8) ? addr_pool[$urandom_range(0, 5)] : ADDR_W'({$urandom, $urandom});
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_command(ACT_REGISTER, nm, ad);
				4, 5:       send_command(ACT_UNREG_NA, nm, ad);
				6:          send_command(ACT_UNREG_A, nm, ad);
				default:    send_command(ACT_LOOKUP, nm, ad);
			endcase
		end
	endtask

	initial begin
		board = new();
		board.clear();
		for (int i = 0; i < 8; i++)
			name_pool[i] = rand_name();
		// Names that differ only after a shared zero byte must compare equal.
		name_pool[0] = 64'h6162_6300_1111_2222;
		name_pool[1] = 64'h6162_6300_3333_4444;
		name_pool[2] = '1;
		name_pool[3] = '0;
		for (int i = 0; i < 6; i++)
			addr_pool[i] = ADDR_W'({$urandom, $urandom});
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every action, early-stop name compare, duplicates.
		send_command(ACT_LOOKUP, '0, '0);
		send_command(ACT_REGISTER, '1, '1);
		send_command(ACT_REGISTER, '1, '1);
		send_command(ACT_REGISTER, '0, '0);
		send_command(ACT_REGISTER, name_pool[0], addr_pool[2]);
		send_command(ACT_REGISTER, name_pool[1], addr_pool[2]);
		send_command(ACT_LOOKUP, name_pool[1], '0);
		send_command(ACT_LOOKUP, '1, '0);
		send_command(ACT_UNREG_NA, name_pool[1], addr_pool[2]);
		send_command(ACT_UNREG_NA, name_pool[1], addr_pool[2]);
		send_command(ACT_UNREG_A, '0, '1);
		send_command(ACT_UNREG_A, '0, addr_pool[3]);
		send_command(ACT_LOOKUP, '0, '1);
		drain();

		// Size zero: everything full or unmatched.
		write_reg(REG_TABLE_SIZE, 32'd0);
		send_command(ACT_REGISTER, '1, '1);
		send_command(ACT_LOOKUP, '1, '0);
		send_command(ACT_UNREG_A, '0, '1);
		drain();

		// Size one fills at once; then saturated and mid sizes with random traffic.
		write_reg(REG_TABLE_SIZE, 32'd1);
		send_command(ACT_REGISTER, name_pool[4], addr_pool[4]);
		send_command(ACT_REGISTER, name_pool[5], addr_pool[5]);
		random_phase(30);
		drain();
		write_reg(REG_TABLE_SIZE, 32'd63);
		random_phase(70);
		drain();
		write_reg(REG_TABLE_SIZE, 32'hFFFF_FFC5);
		random_phase(60);
		drain();
		write_reg(REG_TABLE_SIZE, 32'd32);
		random_phase(60);
		drain();

		if (board.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
